>>> rtl/core/brdm_pkg.sv
// ----------------------------------------------------------------------------
// brdm_pkg
// Shared types and constants for the battery drain rate monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package brdm_pkg;

   localparam int LEVEL_W   = 14;
   localparam int TIME_W    = 32;
   localparam int CHAN_W    = 2;
   localparam int RATE_W    = 18;
   localparam int RATE_MAG_W = 17;
   localparam int SPAN_CFG_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // Shared divider geometry: 24-bit dividend covers level delta * 1000.
   localparam int DIV_N_W   = 24;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = 5;
   localparam int RATE_ITERS = DIV_N_W;
   localparam int EST_ITERS  = LEVEL_W;
   localparam int EST_PAD    = DIV_N_W - LEVEL_W;

   localparam logic [LEVEL_W-1:0]    LEVEL_MAX = 14'd10000;
   localparam logic [LEVEL_W-1:0]    EST_MAX   = 14'd10000;
   localparam logic [RATE_MAG_W-1:0] RATE_MAX  = 17'd100000;
   localparam logic [9:0]            MS_PER_S  = 10'd1000;

   localparam logic [16:0] WARN_RATE_RST  = 17'd150;
   localparam logic [13:0] CRIT_LEVEL_RST = 14'd2000;
   localparam logic [15:0] MIN_SPAN_RST   = 16'd100;
   localparam logic [16:0] RATE_FLOOR_RST = 17'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WARN_RATE  = 2'd0,
      CSR_CRIT_LEVEL = 2'd1,
      CSR_MIN_SPAN   = 2'd2,
      CSR_RATE_FLOOR = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  channel;
      logic [TIME_W-1:0]  sample_time_ms;
      logic [LEVEL_W-1:0] battery_level;
   } req_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] level_rate;
      logic                     rate_warning;
      logic [LEVEL_W-1:0]       secs_to_critical;
      logic [LEVEL_W-1:0]       secs_to_empty;
      logic                     estimate_infinite;
   } rsp_type;

   typedef enum logic [1:0] {
      DIV_RATE  = 2'd0,
      DIV_CRIT  = 2'd1,
      DIV_EMPTY = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SPAN,
      ST_CHECK,
      ST_RATE_DIV,
      ST_STATE,
      ST_CRIT_DIV,
      ST_EMPTY_DIV,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic        load_req;
      logic        lookup;
      logic        span_capture;
      logic        div_start;
      div_sel_type div_sel;
      logic        rate_capture;
      logic        state_write;
      logic        crit_capture;
      logic        empty_capture;
      logic        result_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic chan_invalid;
      logic update_ok;
      logic infinite;
      logic crit_needed;
      logic div_busy;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/core/brdm_divider.sv
// ----------------------------------------------------------------------------
// brdm_divider
// Restoring divider, one quotient bit per cycle, run length set per start.
// ----------------------------------------------------------------------------
`default_nettype none

module brdm_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [brdm_pkg::DIV_N_W-1:0]      dividend,
   input  wire logic [brdm_pkg::DIV_D_W-1:0]      divisor,
   input  wire logic [brdm_pkg::DIV_CNT_W-1:0]    iter_count,
   output logic                                   busy,
   output logic [brdm_pkg::DIV_N_W-1:0]           quotient
);

   localparam int NW = brdm_pkg::DIV_N_W;
   localparam int DW = brdm_pkg::DIV_D_W;

   logic [NW-1:0]                    dvd_ff, dvd_in;
   logic [NW-1:0]                    q_ff, q_in;
   logic [DW-1:0]                    dvs_ff, dvs_in;
   logic [DW-1:0]                    rem_ff, rem_in;
   logic [brdm_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic [DW:0]                      trial;
   logic [DW:0]                      diff;

   always_comb begin
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, dvd_ff[NW-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = iter_count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so DW bits hold it
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         dvd_in  = {dvd_ff[NW-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != brdm_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

>>> rtl/core/brdm_datapath.sv
// ----------------------------------------------------------------------------
// brdm_datapath
// Config registers, per-channel state and sample window memories, span and
// rate arithmetic, estimate formatting and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module brdm_datapath #(
   parameter int CHANNELS = 4,
   parameter int WINDOW   = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire brdm_pkg::req_type                     req_data,
   input  wire logic                                  csr_write,
   input  wire logic [brdm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [brdm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire brdm_pkg::ctrl_cmd_type                cmd,
   output brdm_pkg::dp_status_type                    sts,
   output brdm_pkg::rsp_type                          rsp_data
);

   localparam int LW        = brdm_pkg::LEVEL_W;
   localparam int TW        = brdm_pkg::TIME_W;
   localparam int RW        = brdm_pkg::RATE_W;
   localparam int NW        = brdm_pkg::DIV_N_W;
   localparam int DW        = brdm_pkg::DIV_D_W;
   localparam int FILL_W    = $clog2(WINDOW + 1);
   localparam int PTR_W     = $clog2(WINDOW);
   localparam int SUM_W     = PTR_W + 1;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WIN_DEPTH = CHANNELS * WINDOW;
   localparam int WIN_AW    = $clog2(WIN_DEPTH);
   localparam int CS_W      = FILL_W + PTR_W + RW;
   localparam int WIN_W     = TW + LW;

   // configuration registers
   logic [16:0] warn_rate_ff;
   logic [13:0] crit_level_ff;
   logic [15:0] min_span_ff;
   logic [16:0] rate_floor_ff;

   // memories
   logic [CS_W-1:0]  cs_mem [CHANNELS];
   logic [WIN_W-1:0] win_mem [WIN_DEPTH];
   logic [CHANNELS-1:0] cs_valid_ff;

   // transaction registers
   logic [CH_W-1:0]   chan_ff;
   logic              invalid_ff;
   logic [TW-1:0]     time_ff;
   logic [LW-1:0]     lvl_ff;
   logic [CS_W-1:0]   cs_rd_ff;
   logic              cs_hit_ff;
   logic [WIN_W-1:0]  win_rd_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [PTR_W-1:0]  oldest_ff;
   logic signed [RW-1:0] held_ff;
   logic [TW-1:0]     span_ff;
   logic [NW-1:0]     prod_ff;
   logic              neg_ff;
   logic              update_ff;
   logic              warn_ff;
   logic [LW-1:0]     crit_ff;
   logic [LW-1:0]     empty_ff;
   brdm_pkg::rsp_type rsp_ff;

   // accept side
   logic [CH_W-1:0] req_ch;
   logic [LW-1:0]   req_lvl;
   logic            req_bad;

   // lookup side
   logic [FILL_W-1:0]    cur_fill;
   logic [PTR_W-1:0]     cur_oldest;
   logic signed [RW-1:0] cur_held;
   logic                 not_full;
   logic [SUM_W-1:0]     pos_sum;
   logic [SUM_W-1:0]     pos_wrap;
   logic [PTR_W-1:0]     pos;
   logic [PTR_W-1:0]     pos_inc;
   logic [FILL_W-1:0]    new_fill;
   logic [PTR_W-1:0]     new_oldest;
   logic [WIN_AW-1:0]    win_base;
   logic [WIN_AW-1:0]    win_wr_addr;
   logic [WIN_AW-1:0]    win_rd_addr;

   // span side
   logic [TW-1:0] old_time;
   logic [LW-1:0] old_lvl;
   logic [TW-1:0] span;
   logic          lvl_rise;
   logic [LW-1:0] lvl_delta;
   logic [NW-1:0] prod;
   logic          span_ok;

   // divider side
   logic [NW-1:0]                  div_dvd;
   logic [DW-1:0]                  div_dvs;
   logic [brdm_pkg::DIV_CNT_W-1:0] div_iters;
   logic                           div_busy;
   logic [NW-1:0]                  div_q;
   logic [RW-2:0]                  rate_mag;
   logic signed [RW-1:0]           rate_pos;
   logic signed [RW-1:0]           rate_new;
   logic [LW-1:0]                  est_sat;
   logic [LW-1:0]                  lvl_above_crit;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_rate_ff  <= brdm_pkg::WARN_RATE_RST;
         crit_level_ff <= brdm_pkg::CRIT_LEVEL_RST;
         min_span_ff   <= brdm_pkg::MIN_SPAN_RST;
         rate_floor_ff <= brdm_pkg::RATE_FLOOR_RST;
      end else if (csr_write) begin
         case (csr_index)
            brdm_pkg::CSR_WARN_RATE:  warn_rate_ff  <= csr_wdata;
            brdm_pkg::CSR_CRIT_LEVEL: crit_level_ff <= csr_wdata[13:0];
            brdm_pkg::CSR_MIN_SPAN:   min_span_ff   <= csr_wdata[15:0];
            brdm_pkg::CSR_RATE_FLOOR: rate_floor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- accept ----
   assign req_ch  = CH_W'(req_data.channel);
   assign req_bad = !(32'(req_data.channel) < 32'(CHANNELS));
   assign req_lvl = (req_data.battery_level > brdm_pkg::LEVEL_MAX) ?
                    brdm_pkg::LEVEL_MAX : req_data.battery_level;

   // ---- lookup: ring position and oldest entry ----
   always_comb begin
      cur_fill   = cs_hit_ff ? cs_rd_ff[CS_W-1 -: FILL_W] : '0;
      cur_oldest = cs_hit_ff ? cs_rd_ff[RW +: PTR_W] : '0;
      cur_held   = cs_hit_ff ? $signed(cs_rd_ff[RW-1:0]) : '0;
      not_full   = cur_fill < FILL_W'(WINDOW);
      pos_sum    = SUM_W'(cur_oldest) + SUM_W'(cur_fill);
      pos_wrap   = (pos_sum >= SUM_W'(WINDOW)) ? pos_sum - SUM_W'(WINDOW) : pos_sum;
      pos        = not_full ? PTR_W'(pos_wrap) : cur_oldest;
      pos_inc    = (pos == PTR_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
      new_fill   = not_full ? cur_fill + 1'b1 : cur_fill;
      new_oldest = not_full ? cur_oldest : pos_inc;
      win_base    = WIN_AW'(int'(chan_ff) * WINDOW);
      win_wr_addr = win_base + WIN_AW'(pos);
      win_rd_addr = win_base + WIN_AW'(new_oldest);
   end

   // ---- span and level delta ----
   always_comb begin
      old_time  = win_rd_ff[WIN_W-1 -: TW];
      old_lvl   = win_rd_ff[LW-1:0];
      span      = time_ff - old_time;
      lvl_rise  = lvl_ff > old_lvl;
      lvl_delta = lvl_rise ? lvl_ff - old_lvl : old_lvl - lvl_ff;
      prod      = NW'(lvl_delta) * NW'(brdm_pkg::MS_PER_S);
      span_ok   = (fill_ff >= FILL_W'(2)) && (span > TW'(min_span_ff));
   end

   // ---- divider operand select ----
   assign lvl_above_crit = lvl_ff - crit_level_ff;

   always_comb begin
      case (cmd.div_sel)
         brdm_pkg::DIV_RATE: begin
            div_dvd   = prod_ff;
            div_dvs   = span_ff;
            div_iters = brdm_pkg::DIV_CNT_W'(brdm_pkg::RATE_ITERS);
         end
         brdm_pkg::DIV_CRIT: begin
            div_dvd   = {lvl_above_crit, {brdm_pkg::EST_PAD{1'b0}}};
            div_dvs   = DW'(held_ff[RW-2:0]);
            div_iters = brdm_pkg::DIV_CNT_W'(brdm_pkg::EST_ITERS);
         end
         brdm_pkg::DIV_EMPTY: begin
            div_dvd   = {lvl_ff, {brdm_pkg::EST_PAD{1'b0}}};
            div_dvs   = DW'(held_ff[RW-2:0]);
            div_iters = brdm_pkg::DIV_CNT_W'(brdm_pkg::EST_ITERS);
         end
         default: begin
            div_dvd   = prod_ff;
            div_dvs   = span_ff;
            div_iters = brdm_pkg::DIV_CNT_W'(brdm_pkg::RATE_ITERS);
         end
      endcase
   end

   brdm_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.div_start),
      .dividend   (div_dvd),
      .divisor    (div_dvs),
      .iter_count (div_iters),
      .busy       (div_busy),
      .quotient   (div_q)
   );

   // rate clamp and sign
   always_comb begin
      rate_mag = (div_q > NW'(brdm_pkg::RATE_MAX)) ? brdm_pkg::RATE_MAX : div_q[RW-2:0];
      rate_pos = $signed({1'b0, rate_mag});
      rate_new = neg_ff ? -rate_pos : rate_pos;
      est_sat  = (div_q > NW'(brdm_pkg::EST_MAX)) ? brdm_pkg::EST_MAX : div_q[LW-1:0];
   end

   // ---- state valid bits ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cs_valid_ff <= '0;
      end else if (cmd.state_write) begin
         cs_valid_ff[chan_ff] <= 1'b1;
      end
   end

   // ---- memories ----
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cs_rd_ff <= cs_mem[req_ch];
      end
      if (cmd.state_write) begin
         cs_mem[chan_ff] <= {fill_ff, oldest_ff, held_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         win_mem[win_wr_addr] <= {time_ff, lvl_ff};
         win_rd_ff            <= win_mem[win_rd_addr];
      end
   end

   // ---- transaction registers ----
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         chan_ff    <= req_ch;
         invalid_ff <= req_bad;
         time_ff    <= req_data.sample_time_ms;
         lvl_ff     <= req_lvl;
         cs_hit_ff  <= cs_valid_ff[req_ch];
         warn_ff    <= 1'b0;
         crit_ff    <= '0;
         empty_ff   <= '0;
      end
      if (cmd.lookup) begin
         fill_ff   <= new_fill;
         oldest_ff <= new_oldest;
         held_ff   <= cur_held;
      end
      if (cmd.span_capture) begin
         span_ff   <= span;
         prod_ff   <= prod;
         neg_ff    <= lvl_rise;
         update_ff <= span_ok;
      end
      if (cmd.rate_capture) begin
         held_ff <= rate_new;
         warn_ff <= rate_new > $signed({1'b0, warn_rate_ff});
      end
      if (cmd.crit_capture) begin
         crit_ff <= est_sat;
      end
      if (cmd.empty_capture) begin
         empty_ff <= est_sat;
      end
      if (cmd.result_load) begin
         rsp_ff.level_rate        <= invalid_ff ? '0 : held_ff;
         rsp_ff.rate_warning      <= !invalid_ff && warn_ff;
         rsp_ff.secs_to_critical  <= invalid_ff ? '0 : crit_ff;
         rsp_ff.secs_to_empty     <= invalid_ff ? '0 : empty_ff;
         rsp_ff.estimate_infinite <= invalid_ff || sts.infinite;
      end
   end

   // ---- status ----
   always_comb begin
      sts.chan_invalid = invalid_ff;
      sts.update_ok    = update_ff;
      sts.infinite     = !(held_ff > $signed({1'b0, rate_floor_ff}));
      sts.crit_needed  = lvl_ff > crit_level_ff;
      sts.div_busy     = div_busy;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/core/brdm_ctrl.sv
// ----------------------------------------------------------------------------
// brdm_ctrl
// Sequencer: steps one transaction through lookup, rate divide, estimate
// divides and result hand-off; owns the handshake flags.
// ----------------------------------------------------------------------------
`default_nettype none

module brdm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire brdm_pkg::dp_status_type  sts,
   output brdm_pkg::ctrl_cmd_type        cmd
);

   brdm_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brdm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         brdm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = brdm_pkg::ST_LOOKUP;
            end
         end
         brdm_pkg::ST_LOOKUP: begin
            if (sts.chan_invalid) begin
               state_in = brdm_pkg::ST_DONE;
            end else begin
               cmd.lookup = 1'b1;
               state_in   = brdm_pkg::ST_SPAN;
            end
         end
         brdm_pkg::ST_SPAN: begin
            cmd.span_capture = 1'b1;
            state_in         = brdm_pkg::ST_CHECK;
         end
         brdm_pkg::ST_CHECK: begin
            if (sts.update_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = brdm_pkg::DIV_RATE;
               state_in      = brdm_pkg::ST_RATE_DIV;
            end else begin
               state_in = brdm_pkg::ST_STATE;
            end
         end
         brdm_pkg::ST_RATE_DIV: begin
            if (!sts.div_busy) begin
               cmd.rate_capture = 1'b1;
               state_in         = brdm_pkg::ST_STATE;
            end
         end
         brdm_pkg::ST_STATE: begin
            cmd.state_write = 1'b1;
            if (sts.infinite) begin
               state_in = brdm_pkg::ST_DONE;
            end else if (sts.crit_needed) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = brdm_pkg::DIV_CRIT;
               state_in      = brdm_pkg::ST_CRIT_DIV;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = brdm_pkg::DIV_EMPTY;
               state_in      = brdm_pkg::ST_EMPTY_DIV;
            end
         end
         brdm_pkg::ST_CRIT_DIV: begin
            if (!sts.div_busy) begin
               cmd.crit_capture = 1'b1;
               cmd.div_start    = 1'b1;
               cmd.div_sel      = brdm_pkg::DIV_EMPTY;
               state_in         = brdm_pkg::ST_EMPTY_DIV;
            end
         end
         brdm_pkg::ST_EMPTY_DIV: begin
            if (!sts.div_busy) begin
               cmd.empty_capture = 1'b1;
               state_in          = brdm_pkg::ST_DONE;
            end
         end
         brdm_pkg::ST_DONE: begin
            // wait for the result register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = brdm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brdm_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == brdm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/battery_drain_rate_monitor.sv
// ----------------------------------------------------------------------------
// battery_drain_rate_monitor
// Per-channel sliding window drain rate and time-to-level estimator.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one timestamped level sample per transaction (channel, time, level).
//   rsp_*  : exactly one result per accepted sample, in order: held drain rate,
//            warning, seconds to critical and to empty, infinite flag.
//   csr_*  : register writes (index 0 warn_rate, 1 critical_level,
//            2 min_span_ms, 3 rate_floor); always ready, write only when idle.
// Sequence: one sample at a time. A sample runs the rate divide when its span
//   qualifies, then the critical estimate divide when its level is above
//   critical, then the empty estimate divide; an infinite estimate skips both
//   estimates and a bad channel goes straight to the result. The shared one-bit-per-cycle
//   divider runs 24 steps for the rate and 14 steps for each estimate.
// Flow: req_ready is high in the idle state only, so a new sample is accepted
//   only once the previous one has been handed to the result register.
// Stall: a finished result sits in the output register; the next sample is
//   accepted and processed meanwhile, and only its hand-off waits for rsp_ready.
// Reset: synchronous, active high. Registers return to defaults, all channel
//   windows read as empty; window memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_drain_rate_monitor #(
   parameter int CHANNELS = 4,
   parameter int WINDOW   = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire brdm_pkg::req_type                   req_data,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output brdm_pkg::rsp_type                        rsp_data,
   // register write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [brdm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [brdm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   brdm_pkg::ctrl_cmd_type  cmd;
   brdm_pkg::dp_status_type sts;

   // register writes never stall
   assign csr_ready = 1'b1;

   brdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brdm_datapath #(
      .CHANNELS (CHANNELS),
      .WINDOW   (WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/core/brdm_checker.sv
// ----------------------------------------------------------------------------
// brdm_checker
// Port-level checks for the drain rate monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brdm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire brdm_pkg::rsp_type rsp_data
);

   // held result does not move while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // one sample in flight: ready drops after every accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second sample accepted while busy");

   // finite estimate implies a positive rate
   a_finite_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.estimate_infinite |->
         !rsp_data.level_rate[17] && rsp_data.level_rate != '0)
      else $error("finite estimate with non-positive rate");

   // time to critical never exceeds time to empty
   a_est_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.secs_to_critical <= rsp_data.secs_to_empty)
      else $error("critical estimate beyond empty estimate");

   // warning only with a positive rate
   a_warn_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rate_warning |->
         !rsp_data.level_rate[17] && rsp_data.level_rate != '0)
      else $error("warning with non-positive rate");

endmodule

bind battery_drain_rate_monitor brdm_checker u_brdm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/tb_battery_drain_rate_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_drain_rate_monitor
// Self-checking bench for the battery drain rate monitor. A scoreboard class
// keeps its own per-channel sample windows and register copies, predicts the
// held drain rate, warning and time estimates for every accepted sample, and
// checks each result transaction in order. Stimulus is a directed pass over
// the corner cases followed by randomized phases of drifting level streams
// under several register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

module tb_battery_drain_rate_monitor;

   localparam int NUM_CHANNELS = 4;
   localparam int WINDOW_DEPTH = 10;
   localparam int QUIET_LIMIT  = 3000;   // cycles with no handshake at all
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 80;

   // receiver modes
   localparam int RX_FREE  = 0;
   localparam int RX_COIN  = 1;
   localparam int RX_STALL = 2;

   // -------------------------------------------------------------------------
   // Scoreboard: drain rate predictor plus in-order result check
   // -------------------------------------------------------------------------
   class slope_scoreboard;
      logic [16:0]        warn_lim;
      logic [13:0]        crit_lvl;
      logic [15:0]        min_span;
      logic [16:0]        floor_lim;
      logic [31:0]        win_time  [NUM_CHANNELS][WINDOW_DEPTH];
      logic [13:0]        win_level [NUM_CHANNELS][WINDOW_DEPTH];
      int unsigned        fill      [NUM_CHANNELS];
      int unsigned        head      [NUM_CHANNELS];
      logic signed [17:0] rate_held [NUM_CHANNELS];
      brdm_pkg::rsp_type  predicted_rsp [$];
      int                 mismatch_count;

      function new();
         warn_lim  = brdm_pkg::WARN_RATE_RST;
         crit_lvl  = brdm_pkg::CRIT_LEVEL_RST;
         min_span  = brdm_pkg::MIN_SPAN_RST;
         floor_lim = brdm_pkg::RATE_FLOOR_RST;
         mismatch_count = 0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            fill[c] = 0;
            head[c] = 0;
            rate_held[c] = '0;
         end
      endfunction

      function void set_register(brdm_pkg::csr_index_type idx, logic [16:0] val);
         case (idx)
            brdm_pkg::CSR_WARN_RATE:  warn_lim  = val;
            brdm_pkg::CSR_CRIT_LEVEL: crit_lvl  = val[13:0];
            brdm_pkg::CSR_MIN_SPAN:   min_span  = val[15:0];
            brdm_pkg::CSR_RATE_FLOOR: floor_lim = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return predicted_rsp.size();
      endfunction

      // Update the channel window with one accepted sample and queue its result.
      function void note_sample(brdm_pkg::req_type s);
         int unsigned       ch, pos;
         logic [13:0]       lvl, old_lvl;
         logic [31:0]       span;
         logic              rising;
         longint unsigned   mag, quo;
         logic signed [17:0] r;
         int unsigned       ur, est;
         brdm_pkg::rsp_type e;

         ch  = s.channel;
         lvl = (s.battery_level > brdm_pkg::LEVEL_MAX) ? brdm_pkg::LEVEL_MAX
                                                       : s.battery_level;
         e   = '0;
         e.estimate_infinite = 1'b1;

         // ring insert: append while filling, overwrite oldest once full
         if (fill[ch] < WINDOW_DEPTH) begin
            pos = (head[ch] + fill[ch]) % WINDOW_DEPTH;
            fill[ch]++;
         end else begin
            pos = head[ch];
            head[ch] = (pos + 1) % WINDOW_DEPTH;
         end
         win_time[ch][pos]  = s.sample_time_ms;
         win_level[ch][pos] = lvl;

         if (fill[ch] >= 2) begin
            span = s.sample_time_ms - win_time[ch][head[ch]];   // wraps mod 2^32
            if (span > min_span) begin
               old_lvl = win_level[ch][head[ch]];
               rising  = lvl > old_lvl;
               mag = 64'(rising ? lvl - old_lvl : old_lvl - lvl) * 64'd1000;
               quo = mag / 64'(span);
               if (quo > 64'(brdm_pkg::RATE_MAX))
                  quo = 64'(brdm_pkg::RATE_MAX);
               r = 18'(quo);
               rate_held[ch] = rising ? -r : r;
               e.rate_warning = rate_held[ch] > $signed({1'b0, warn_lim});
            end
         end

         e.level_rate = rate_held[ch];
         if (rate_held[ch] > $signed({1'b0, floor_lim})) begin
            ur = rate_held[ch][16:0];
            e.estimate_infinite = 1'b0;
            est = (lvl > crit_lvl) ? (lvl - crit_lvl) / ur : 0;
            e.secs_to_critical = (est > brdm_pkg::EST_MAX) ? brdm_pkg::EST_MAX : est[13:0];
            est = lvl / ur;
            e.secs_to_empty = (est > brdm_pkg::EST_MAX) ? brdm_pkg::EST_MAX : est[13:0];
         end
         predicted_rsp = {predicted_rsp, e};
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_result(brdm_pkg::rsp_type got);
         brdm_pkg::rsp_type want;
         if (predicted_rsp.size() == 0) begin
            report("result transaction with no sample outstanding");
            return;
         end
         want = predicted_rsp[0];
         predicted_rsp.delete(0);
         if (got.level_rate !== want.level_rate)
            report($sformatf("level_rate got %0d want %0d",
                             got.level_rate, want.level_rate));
         if (got.rate_warning !== want.rate_warning)
            report($sformatf("rate_warning got %0b want %0b",
                             got.rate_warning, want.rate_warning));
         if (got.secs_to_critical !== want.secs_to_critical)
            report($sformatf("secs_to_critical got %0d want %0d",
                             got.secs_to_critical, want.secs_to_critical));
         if (got.secs_to_empty !== want.secs_to_empty)
            report($sformatf("secs_to_empty got %0d want %0d",
                             got.secs_to_empty, want.secs_to_empty));
         if (got.estimate_infinite !== want.estimate_infinite)
            report($sformatf("estimate_infinite got %0b want %0b",
                             got.estimate_infinite, want.estimate_infinite));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   brdm_pkg::req_type       req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   brdm_pkg::rsp_type       rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   brdm_pkg::csr_index_type csr_index = brdm_pkg::CSR_WARN_RATE;
   logic [16:0]             csr_wdata = '0;

   slope_scoreboard sb;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   battery_drain_rate_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Monitor and watchdog: everything is sampled on the rising edge.
   // Results are checked before the same-edge sample is noted; with one sample
   // in flight at a time the order does not matter, but it keeps things clear.
   // -------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         if (req_valid && req_ready)
            sb.note_sample(req_data);
         if (csr_valid && csr_ready)
            sb.set_register(csr_index, csr_wdata);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stretches of always-ready, coin-flip ready, and hard stall
   // -------------------------------------------------------------------------
   int rx_mode = RX_FREE;
   int rx_left = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(RX_FREE, RX_STALL);
         rx_left = (rx_mode == RX_STALL) ? $urandom_range(1, 20) : $urandom_range(1, 40);
      end
      rx_left--;
      case (rx_mode)
         RX_FREE: rsp_ready <= 1'b1;
         RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= 1'b0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Sender tasks; all called at a falling edge and return at a falling edge
   // -------------------------------------------------------------------------
   int burst_left = 0;

   // Bursty sender: valid stays up across back-to-back transactions inside a
   // burst, and drops for a random gap between bursts.
   task automatic send_sample(input brdm_pkg::req_type s);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_data  <= s;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic brdm_pkg::req_type make_sample(int unsigned ch, logic [31:0] t,
                                                     int unsigned lvl);
      brdm_pkg::req_type s;
      s.channel        = ch[1:0];
      s.sample_time_ms = t;
      s.battery_level  = lvl[13:0];
      return s;
   endfunction

   // Drop valid and hold off until every outstanding result has been taken.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic put_register(input brdm_pkg::csr_index_type idx,
                               input logic [16:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Registers only change with the block idle.
   task automatic apply_config(input logic [16:0] warn, input logic [16:0] crit,
                               input logic [16:0] span, input logic [16:0] flr);
      wait_idle();
      put_register(brdm_pkg::CSR_WARN_RATE,  warn);
      put_register(brdm_pkg::CSR_CRIT_LEVEL, crit);
      put_register(brdm_pkg::CSR_MIN_SPAN,   span);
      put_register(brdm_pkg::CSR_RATE_FLOOR, flr);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0] track_time  [NUM_CHANNELS];
      int          track_level [NUM_CHANNELS];
      logic [16:0] cfg_warn, cfg_crit, cfg_span, cfg_floor;
      int unsigned step_max, drop_max, ch, lvl;
      logic [31:0] t;

      sb = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed, reset register values (warn 150, crit 2000, span 100) ---
      send_sample(make_sample(0, 32'd1000, 10000));   // first sample: no rate yet
      send_sample(make_sample(0, 32'd1000, 9990));    // zero span, rate held
      send_sample(make_sample(0, 32'd1100, 9950));    // span equal to minimum
      send_sample(make_sample(0, 32'd1101, 9900));    // first update, warning
      send_sample(make_sample(0, 32'd1500, 16383));   // level saturates to full
      send_sample(make_sample(0, 32'd2000, 0));       // empty level
      send_sample(make_sample(1, 32'hFFFF_FF00, 5000));
      send_sample(make_sample(1, 32'h0000_0100, 4000)); // span across time wrap
      send_sample(make_sample(1, 32'h0000_0200, 1500)); // below critical
      send_sample(make_sample(2, 32'd0, 100));
      send_sample(make_sample(2, 32'd500, 9000));     // charging: negative rate
      send_sample(make_sample(3, 32'hFFFF_FFFF, 10000));

      // --- directed, low extremes: every nonzero span counts, every positive rate warns ---
      apply_config(17'd0, 17'd0, 17'd0, 17'd0);
      send_sample(make_sample(3, 32'd0, 0));          // 1 ms span: positive clamp
      send_sample(make_sample(2, 32'd1, 10000));      // 1 ms span: negative clamp
      send_sample(make_sample(2, 32'd501, 16383));

      // --- directed, high extremes ---
      apply_config(17'd100000, 17'd10000, 17'd65535, 17'd100000);
      send_sample(make_sample(0, 32'd66536, 0));      // span just past maximum
      send_sample(make_sample(0, 32'd66536, 10000));

      // rate exactly at warning threshold and at floor: neither fires
      apply_config(17'd152, 17'd5000, 17'd65535, 17'd152);
      send_sample(make_sample(0, 32'd66536, 0));
      // one below: both fire; the next sample also wraps the channel ring
      apply_config(17'd151, 17'd10000, 17'd65535, 17'd151);
      send_sample(make_sample(0, 32'd66536, 0));
      send_sample(make_sample(0, 32'd66537, 3));

      // --- random phases: drifting level streams per channel, some noise ---
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               cfg_warn = 17'd150; cfg_crit = 17'd2000;
               cfg_span = 17'd100; cfg_floor = 17'd0;
            end
            1: begin
               cfg_warn = 17'd0; cfg_crit = 17'd0; cfg_span = 17'd0; cfg_floor = 17'd0;
            end
            4: begin
               cfg_warn = 17'd100000; cfg_crit = 17'd10000;
               cfg_span = 17'd65535;  cfg_floor = 17'($urandom_range(0, 100));
            end
            default: begin
               cfg_warn  = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 100000))
                                                        : 17'($urandom_range(0, 3000));
               cfg_crit  = 17'($urandom_range(0, 10000));
               cfg_span  = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 65535))
                                                        : 17'($urandom_range(0, 300));
               cfg_floor = 17'($urandom_range(0, 300));
            end
         endcase
         apply_config(cfg_warn, cfg_crit, cfg_span, cfg_floor);

         step_max = cfg_span / 4 + 60;
         drop_max = $urandom_range(0, 400);
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            // some streams start just short of the time wrap
            track_time[c]  = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                             - $urandom_range(0, 4 * step_max) : $urandom();
            track_level[c] = $urandom_range(2000, 16383);
         end

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // occasional full drain mid-phase
            if ($urandom_range(0, 39) == 0)
               wait_idle();
            ch = $urandom_range(0, NUM_CHANNELS - 1);
            if ($urandom_range(0, 9) == 0) begin
               // noise: any time, any level including above full scale
               t   = $urandom();
               lvl = $urandom_range(0, 16383);
            end else begin
               track_time[ch] += $urandom_range(0, step_max);
               if ($urandom_range(0, 7) == 0)
                  track_level[ch] += $urandom_range(0, 500);
               else
                  track_level[ch] -= $urandom_range(0, drop_max);
               if (track_level[ch] <= 0)
                  track_level[ch] = ($urandom_range(0, 3) == 0) ? 0
                                    : $urandom_range(5000, 16383);
               if (track_level[ch] > 16383)
                  track_level[ch] = 16383;
               t   = track_time[ch];
               lvl = track_level[ch];
            end
            send_sample(make_sample(ch, t, lvl));
         end
      end

      // --- drain and finish ---
      wait_idle();
      repeat (100) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
